[rtl/fexp_pkg.sv]
// fexp_pkg: shared types, constants and helpers for the exponential series core
`timescale 1ns / 1ps

package fexp_pkg;

  // 1.0 in Q16.16
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // largest term count with a factorial in the table
  localparam int MAX_TERMS = 12;

  // k! for k = 0..12
  localparam logic [31:0] FACT_TAB [0:MAX_TERMS] = '{
    32'd1, 32'd1, 32'd2, 32'd6, 32'd24, 32'd120, 32'd720, 32'd5040,
    32'd40320, 32'd362880, 32'd3628800, 32'd39916800, 32'd479001600
  };

  // data that travels with one argument between series terms
  typedef struct packed {
    logic signed [31:0] pw;   // current power of x, Q16.16
    logic        [31:0] mag;  // magnitude of pw
    logic               neg;  // sign of pw
    logic signed [31:0] x;    // the argument itself
    logic        [31:0] sum;  // running sum, wraps at 32 bits
  } fexp_stage_t;

  // magnitude of a two's complement word (-2^31 gives 2^31)
  function automatic logic [31:0] fexp_abs(input logic [31:0] v);
    fexp_abs = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

[rtl/fexp_term.sv]
// fexp_term: one series term, next power and p_k / k! folded into the running sum
`timescale 1ns / 1ps

module fexp_term
  import fexp_pkg::*;
#(
  parameter int K = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  fexp_stage_t in_stage,
  output logic        out_valid,
  output fexp_stage_t out_stage
);

  // reciprocal for exact floor(n / k!) over all 32-bit n
  localparam logic [31:0] FACT    = FACT_TAB[K];
  localparam int          SHIFT_L = $clog2(FACT);
  localparam int          SHIFT_T = 32 + SHIFT_L;
  localparam logic [63:0] MAGIC_FULL = ((64'd1 << SHIFT_T) / FACT) + 64'd1;
  localparam logic [33:0] MAGIC   = MAGIC_FULL[33:0];

  logic               a_valid;
  logic signed [63:0] a_prod;
  logic        [65:0] a_est;
  logic               a_neg;
  logic signed [31:0] a_x;
  logic        [31:0] a_sum;

  logic        [65:0] est_shift;
  logic        [31:0] quot;
  logic signed [31:0] pw_next;

  // multiply stage: next power and scaled magnitude side by side
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_prod <= $signed(in_stage.pw) * $signed(in_stage.x);
    a_est  <= {34'b0, in_stage.mag} * {32'b0, MAGIC};
    a_neg  <= in_stage.neg;
    a_x    <= in_stage.x;
    a_sum  <= in_stage.sum;
  end

  // quotient magnitude and the Q16.16 power, floor shift by 16
  assign est_shift = a_est >> SHIFT_T;
  assign quot      = est_shift[31:0];
  assign pw_next   = a_prod[47:16];

  // accumulate stage: signed quotient truncates toward zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_stage.pw  <= pw_next;
    out_stage.mag <= fexp_abs(pw_next);
    out_stage.neg <= pw_next[31];
    out_stage.x   <= a_x;
    out_stage.sum <= a_neg ? (a_sum - quot) : (a_sum + quot);
  end

endmodule

[rtl/fixed_exp_taylor_core.sv]
// fixed_exp_taylor_core: pipelined e^x in Q16.16 by a truncated Taylor series
//
//   channel   ports                    direction  notes
//   request   start, busy, arg[31:0]   in / out   taken when start && !busy
//   result    done, value[31:0]        out        done high for one cycle
//
// One request per clock cycle, busy never rises.
// The pipeline is an input register, then per term a multiply
// stage (power and reciprocal products) and an accumulate stage.
// rst clears only the valid bits; data in flight at reset is dropped.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module fixed_exp_taylor_core
  import fexp_pkg::*;
#(
  parameter int TERMS = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] arg,
  output logic               done,
  output logic signed [31:0] value
);

  localparam int LATENCY = 2 * TERMS + 1;

  logic        head_valid;
  fexp_stage_t head_stage;

  logic        valid_chain [0:TERMS];
  fexp_stage_t stage_chain [0:TERMS];

  // always ready for the next request
  assign busy = 1'b0;

  // input register: p_1 is the argument itself, sum starts at 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= start && !busy;
    end
    head_stage.pw  <= arg;
    head_stage.mag <= fexp_abs(arg);
    head_stage.neg <= arg[31];
    head_stage.x   <= arg;
    head_stage.sum <= ONE_Q16;
  end

  assign valid_chain[0] = head_valid;
  assign stage_chain[0] = head_stage;

  // one two-stage unit per series term
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    fexp_term #(
      .K(k)
    ) u_term (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid_chain[k-1]),
      .in_stage (stage_chain[k-1]),
      .out_valid(valid_chain[k]),
      .out_stage(stage_chain[k])
    );
  end

  assign done  = valid_chain[TERMS];
  assign value = stage_chain[TERMS].sum;

  // every result traces back to an accepted request
  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // zero argument gives exactly 1.0
  a_zero_gives_one: assert property (@(posedge clk) disable iff (rst)
    (done && $past(arg == 32'sd0, LATENCY)) |-> (value == ONE_Q16))
    else $error("e^0 is not 1.0");

  // one lsb below zero: p_1 = -1 and every higher power floors to zero
  a_minus_lsb: assert property (@(posedge clk) disable iff (rst)
    (done && $past(arg == -32'sd1, LATENCY)) |-> (value == 32'sh0000_ffff))
    else $error("e^-lsb is not 1.0 minus one lsb");

endmodule
